[design/tslt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tslt_pkg
// Shared types and constants for the task slot lifecycle tracker.
// ----------------------------------------------------------------------------
package tslt_pkg;

	localparam int Slots = 64;
	localparam int SlotW = $clog2(Slots);
	localparam int NumStates = 5;

	localparam logic [2:0] ST_FREE = 3'd0;
	localparam logic [2:0] ST_REQUEST = 3'd1;
	localparam logic [2:0] ST_PREPARE = 3'd2;
	localparam logic [2:0] ST_PROCESS = 3'd3;
	localparam logic [2:0] ST_COMPLETE = 3'd4;
	localparam logic [2:0] ST_NONE = 3'd7;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_MOVE = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_FLUSH = 2'd3;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_EMPTY = 3'd1;
	localparam logic [2:0] STS_WRONG = 3'd2;
	localparam logic [2:0] STS_PAIR = 3'd3;
	localparam logic [2:0] STS_BAD = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] slot_number;
		logic [2:0] from_state;
		logic [2:0] to_state;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] granted_slot;
		logic [5:0] free_count;
		logic [5:0] request_count;
		logic [5:0] prepare_count;
		logic [5:0] process_count;
		logic [5:0] complete_count;
	} rsp_t;

	// One entry of the slot memory: state plus both links.
	typedef struct packed {
		logic [2:0] st;
		logic [SlotW-1:0] nxt;
		logic [SlotW-1:0] prv;
	} entry_t;

	// Port request/data between control and slot memory; per-field write enables.
	typedef struct packed {
		logic we_st;
		logic we_nxt;
		logic we_prv;
		logic [SlotW-1:0] waddr;
		entry_t wdata;
		logic [SlotW-1:0] raddr;
	} mem_req_t;

	function automatic logic move_allowed(input logic [2:0] f, input logic [2:0] t);
		logic [4:0] m;
		unique case (f)
			ST_FREE: m = 5'h02;
			ST_REQUEST: m = 5'h1D;
			ST_PREPARE: m = 5'h19;
			ST_PROCESS: m = 5'h11;
			ST_COMPLETE: m = 5'h01;
			default: m = 5'h00;
		endcase
		if (t > ST_COMPLETE) return 1'b0;
		return m[t];
	endfunction

endpackage
`default_nettype wire

[design/task_slot_lifecycle_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_slot_lifecycle_tracker
// Task slot pool with five ordered state lists kept in a slot memory.
// ----------------------------------------------------------------------------
// Steps: an allocate, move or release that succeeds reads, checks, unlinks
//   and relinks it, then outputs; a failed move or release outputs after
//   the check, an allocate with no free slot at once; flush frees every slot.
// Throughput: one request at a time; busy drops in the result cycle, so the
//   next transfer can be taken at the edge that takes the result.
// Reset: after arst_n rises the slot memory is initialized (busy high); the
//   result cannot be stalled by the receiver.
module task_slot_lifecycle_tracker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tslt_pkg::req_t req,
	output logic busy,
	output logic done,
	output tslt_pkg::rsp_t result
);

	// control to memory request, and registered read data back
	tslt_pkg::mem_req_t mreq;
	tslt_pkg::entry_t rdata;

	tslt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result),
		.mreq(mreq), .rdata(rdata)
	);

	tslt_mem u_mem (.clk(clk), .mreq(mreq), .rdata(rdata));

endmodule
`default_nettype wire

[design/tslt_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tslt_mem
// Slot entry memory: one write port with field enables, one registered read.
// ----------------------------------------------------------------------------
module tslt_mem (
	input wire logic clk,
	input wire tslt_pkg::mem_req_t mreq,
	output tslt_pkg::entry_t rdata
);

	tslt_pkg::entry_t mem_q [tslt_pkg::Slots];

	always_ff @(posedge clk) begin
		if (mreq.we_st) begin
			mem_q[mreq.waddr].st <= mreq.wdata.st;
		end
		if (mreq.we_nxt) begin
			mem_q[mreq.waddr].nxt <= mreq.wdata.nxt;
		end
		if (mreq.we_prv) begin
			mem_q[mreq.waddr].prv <= mreq.wdata.prv;
		end
		rdata <= mem_q[mreq.raddr];
	end

endmodule
`default_nettype wire

[design/tslt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tslt_ctrl
// Sequencer: reads slot entries, unlinks, relinks at list tails.
// ----------------------------------------------------------------------------
module tslt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tslt_pkg::req_t req,
	output logic busy,
	output logic done,
	output tslt_pkg::rsp_t result,
	output tslt_pkg::mem_req_t mreq,
	input wire tslt_pkg::entry_t rdata
);

	localparam int SW = tslt_pkg::SlotW;

	typedef enum logic [9:0] {
		S_INIT = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_RD = 10'b0000000100,   // read target entry
		S_CHK = 10'b0000001000,  // entry on rdata: check and latch
		S_WP = 10'b0000010000,   // prev.nxt = next
		S_WN = 10'b0000100000,   // next.prv = prev
		S_WT = 10'b0001000000,   // old dest tail.nxt = slot
		S_SELF = 10'b0010000000, // write slot entry, list registers
		S_FLH = 10'b0100000000,  // flush: pick next list head
		S_OUT = 10'b1000000000
	} fsm_t;

	fsm_t state_q;
	logic [SW-1:0] head_q [tslt_pkg::NumStates];
	logic [SW-1:0] tail_q [tslt_pkg::NumStates];
	logic [SW:0] cnt_q [tslt_pkg::NumStates];
	tslt_pkg::req_t req_q;
	logic [SW-1:0] slot_q;
	logic [2:0] dst_q;
	logic [2:0] sts_q;
	logic [SW-1:0] gnt_q;
	tslt_pkg::entry_t ent_q;
	logic [2:0] fl_q;
	logic [SW-1:0] init_q;
	logic flushing_q;

	logic bad;
	logic [2:0] ost;
	logic [2:0] chk_sts;
	assign bad = (req_q.slot_number == '0);
	assign ost = ent_q.st;

	// status from the checks on the freshly read target entry
	always_comb begin
		chk_sts = tslt_pkg::STS_OK;
		if (!flushing_q && req_q.req_type == tslt_pkg::REQ_MOVE) begin
			priority if (bad) chk_sts = tslt_pkg::STS_BAD;
			else if (!tslt_pkg::move_allowed(req_q.from_state, req_q.to_state))
				chk_sts = tslt_pkg::STS_PAIR;
			else if (cnt_q[req_q.from_state] == '0) chk_sts = tslt_pkg::STS_EMPTY;
			else if (rdata.st != req_q.from_state) chk_sts = tslt_pkg::STS_WRONG;
			else chk_sts = tslt_pkg::STS_OK;
		end else if (!flushing_q && req_q.req_type == tslt_pkg::REQ_RELEASE) begin
			priority if (bad) chk_sts = tslt_pkg::STS_BAD;
			else if (rdata.st == tslt_pkg::ST_FREE || rdata.st > tslt_pkg::ST_COMPLETE)
				chk_sts = tslt_pkg::STS_WRONG;
			else chk_sts = tslt_pkg::STS_OK;
		end
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_INIT: begin
				mreq.we_st = 1'b1;
				mreq.we_nxt = 1'b1;
				mreq.we_prv = 1'b1;
				mreq.waddr = init_q;
				mreq.wdata.st = (init_q == '0) ? tslt_pkg::ST_NONE : tslt_pkg::ST_FREE;
				mreq.wdata.nxt = (init_q == SW'(tslt_pkg::Slots - 1) || init_q == '0) ?
					'0 : init_q + 1'b1;
				mreq.wdata.prv = (init_q <= SW'(1)) ? '0 : init_q - 1'b1;
			end
			S_RD: mreq.raddr = slot_q;
			S_WP: begin
				mreq.we_nxt = (ent_q.prv != '0);
				mreq.waddr = ent_q.prv;
				mreq.wdata.nxt = ent_q.nxt;
			end
			S_WN: begin
				mreq.we_prv = (ent_q.nxt != '0);
				mreq.waddr = ent_q.nxt;
				mreq.wdata.prv = ent_q.prv;
			end
			S_WT: begin
				mreq.we_nxt = (tail_q[dst_q] != '0);
				mreq.waddr = tail_q[dst_q];
				mreq.wdata.nxt = slot_q;
			end
			S_SELF: begin
				mreq.we_st = 1'b1;
				mreq.we_nxt = 1'b1;
				mreq.we_prv = 1'b1;
				mreq.waddr = slot_q;
				mreq.wdata.st = dst_q;
				mreq.wdata.nxt = '0;
				mreq.wdata.prv = tail_q[dst_q];
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			flushing_q <= 1'b0;
			done <= 1'b0;
			fl_q <= '0;
			req_q <= '0;
			slot_q <= '0;
			dst_q <= '0;
			sts_q <= '0;
			gnt_q <= '0;
			ent_q <= '0;
			for (int i = 0; i < tslt_pkg::NumStates; i++) begin
				head_q[i] <= (i == 0) ? SW'(1) : '0;
				tail_q[i] <= (i == 0) ? SW'(tslt_pkg::Slots - 1) : '0;
				cnt_q[i] <= (i == 0) ? (SW+1)'(tslt_pkg::Slots - 1) : '0;
			end
		end else begin
			done <= (state_q == S_OUT);
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == SW'(tslt_pkg::Slots - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						gnt_q <= '0;
						priority if (req.req_type == tslt_pkg::REQ_ALLOC &&
							cnt_q[tslt_pkg::ST_FREE] == '0) begin
							sts_q <= tslt_pkg::STS_EMPTY;
							state_q <= S_OUT;
						end else if (req.req_type == tslt_pkg::REQ_ALLOC) begin
							sts_q <= tslt_pkg::STS_OK;
							slot_q <= head_q[tslt_pkg::ST_FREE];
							dst_q <= tslt_pkg::ST_REQUEST;
							state_q <= S_RD;
						end else if (req.req_type == tslt_pkg::REQ_FLUSH) begin
							sts_q <= tslt_pkg::STS_OK;
							flushing_q <= 1'b1;
							fl_q <= tslt_pkg::ST_REQUEST;
							dst_q <= tslt_pkg::ST_FREE;
							state_q <= S_FLH;
						end else begin
							sts_q <= tslt_pkg::STS_OK;
							slot_q <= req.slot_number;
							dst_q <= (req.req_type == tslt_pkg::REQ_MOVE) ?
								req.to_state : tslt_pkg::ST_FREE;
							state_q <= S_RD;
						end
					end
				end
				S_FLH: begin
					if (fl_q == 3'(tslt_pkg::NumStates)) begin
						flushing_q <= 1'b0;
						state_q <= S_OUT;
					end else if (head_q[fl_q] == '0) begin
						fl_q <= fl_q + 1'b1;
					end else begin
						slot_q <= head_q[fl_q];
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					ent_q <= rdata;
					if (chk_sts != tslt_pkg::STS_OK) begin
						sts_q <= chk_sts;
						state_q <= S_OUT;
					end else begin
						state_q <= S_WP;
					end
				end
				S_WP: state_q <= S_WN;
				S_WN: state_q <= S_WT;
				S_WT: state_q <= S_SELF;
				S_SELF: begin
					// source and destination lists always differ here
					if (ent_q.prv == '0) head_q[ost] <= ent_q.nxt;
					if (ent_q.nxt == '0) tail_q[ost] <= ent_q.prv;
					cnt_q[ost] <= cnt_q[ost] - 1'b1;
					if (tail_q[dst_q] == '0) head_q[dst_q] <= slot_q;
					tail_q[dst_q] <= slot_q;
					cnt_q[dst_q] <= cnt_q[dst_q] + 1'b1;
					if (!flushing_q) gnt_q <= slot_q;
					state_q <= flushing_q ? S_FLH : S_OUT;
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		result = '0;
		result.status = sts_q;
		result.granted_slot = 6'(gnt_q);
		result.free_count = 6'(cnt_q[0]);
		result.request_count = 6'(cnt_q[1]);
		result.prepare_count = 6'(cnt_q[2]);
		result.process_count = 6'(cnt_q[3]);
		result.complete_count = 6'(cnt_q[4]);
	end

`ifndef ASSERT_OFF
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("result outside idle");
	a_cnt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q[0] + cnt_q[1] + cnt_q[2] + cnt_q[3] + cnt_q[4])
		== (SW+1)'(tslt_pkg::Slots - 1)) else $error("slot count lost");
`endif

endmodule
`default_nettype wire

[sim/tslt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tslt_checker
// Watches request and result transfers, runs a slot-list predictor and
// compares each result with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tslt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire tslt_pkg::req_t req,
	input wire logic done,
	input wire tslt_pkg::rsp_t result,
	output int errors,
	output int pending
);

	logic [2:0] st_of [tslt_pkg::Slots];
	logic [5:0] nxt [tslt_pkg::Slots];
	logic [5:0] prv [tslt_pkg::Slots];
	logic [5:0] head [tslt_pkg::NumStates];
	logic [5:0] tail [tslt_pkg::NumStates];
	logic [5:0] cnt [tslt_pkg::NumStates];
	tslt_pkg::rsp_t rsp_q [$];

	function automatic logic pair_legal(input logic [2:0] f, input logic [2:0] t);
		logic [4:0] m;
		case (f)
			tslt_pkg::ST_FREE: m = 5'b00010;
			tslt_pkg::ST_REQUEST: m = 5'b11101;
			tslt_pkg::ST_PREPARE: m = 5'b11001;
			tslt_pkg::ST_PROCESS: m = 5'b10001;
			tslt_pkg::ST_COMPLETE: m = 5'b00001;
			default: m = 5'b0;
		endcase
		if (t > tslt_pkg::ST_COMPLETE) return 1'b0;
		return m[t];
	endfunction

	function automatic void unlink(input logic [5:0] s);
		logic [2:0] k;
		k = st_of[s];
		if (k > tslt_pkg::ST_COMPLETE) return;
		if (prv[s] != 0) nxt[prv[s]] = nxt[s];
		else head[k] = nxt[s];
		if (nxt[s] != 0) prv[nxt[s]] = prv[s];
		else tail[k] = prv[s];
		if (cnt[k] != 0) cnt[k] = cnt[k] - 6'd1;
		nxt[s] = 0;
		prv[s] = 0;
	endfunction

	function automatic void append(input logic [5:0] s, input logic [2:0] k);
		prv[s] = tail[k];
		nxt[s] = 0;
		if (tail[k] != 0) nxt[tail[k]] = s;
		else head[k] = s;
		tail[k] = s;
		cnt[k] = cnt[k] + 6'd1;
		st_of[s] = k;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < tslt_pkg::Slots; i++) begin
			st_of[i] = tslt_pkg::ST_FREE;
			nxt[i] = 0;
			prv[i] = 0;
		end
		for (int k = 0; k < tslt_pkg::NumStates; k++) begin
			head[k] = 0;
			tail[k] = 0;
			cnt[k] = 0;
		end
		st_of[0] = tslt_pkg::ST_NONE;
		for (int i = 1; i < tslt_pkg::Slots; i++) append(i[5:0], tslt_pkg::ST_FREE);
	endfunction

	function automatic tslt_pkg::rsp_t serve(input tslt_pkg::req_t r);
		tslt_pkg::rsp_t o;
		logic bad;
		o = '0;
		o.status = tslt_pkg::STS_OK;
		bad = (r.slot_number == 0);
		case (r.req_type)
			tslt_pkg::REQ_ALLOC: begin
				if (cnt[tslt_pkg::ST_FREE] == 0 || head[tslt_pkg::ST_FREE] == 0)
					o.status = tslt_pkg::STS_EMPTY;
				else begin
					o.granted_slot = head[tslt_pkg::ST_FREE];
					unlink(o.granted_slot);
					append(o.granted_slot, tslt_pkg::ST_REQUEST);
				end
			end
			tslt_pkg::REQ_MOVE: begin
				if (bad) o.status = tslt_pkg::STS_BAD;
				else if (!pair_legal(r.from_state, r.to_state)) o.status = tslt_pkg::STS_PAIR;
				else if (cnt[r.from_state] == 0) o.status = tslt_pkg::STS_EMPTY;
				else if (st_of[r.slot_number] != r.from_state) o.status = tslt_pkg::STS_WRONG;
				else begin
					unlink(r.slot_number);
					append(r.slot_number, r.to_state);
					o.granted_slot = r.slot_number;
				end
			end
			tslt_pkg::REQ_RELEASE: begin
				if (bad) o.status = tslt_pkg::STS_BAD;
				else if (st_of[r.slot_number] == tslt_pkg::ST_FREE ||
						st_of[r.slot_number] > tslt_pkg::ST_COMPLETE)
					o.status = tslt_pkg::STS_WRONG;
				else begin
					unlink(r.slot_number);
					append(r.slot_number, tslt_pkg::ST_FREE);
					o.granted_slot = r.slot_number;
				end
			end
			default: begin
				for (int k = 1; k < tslt_pkg::NumStates; k++) begin
					int guard;
					guard = 0;
					while (head[k] != 0 && guard < tslt_pkg::Slots) begin
						logic [5:0] s;
						s = head[k];
						unlink(s);
						append(s, tslt_pkg::ST_FREE);
						guard++;
					end
				end
			end
		endcase
		o.free_count = cnt[0];
		o.request_count = cnt[1];
		o.prepare_count = cnt[2];
		o.process_count = cnt[3];
		o.complete_count = cnt[4];
		return o;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		pool_reset();
	end

	always @(posedge clk) begin
		tslt_pkg::rsp_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (rsp_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, result);
					errors++;
				end else begin
					exp_r = rsp_q.pop_front();
					if (exp_r !== result) begin
						$display("%0t result mismatch: expected %h, actual %h",
							$time, exp_r, result);
						if (exp_r.status !== result.status)
							$display("%0t  status: expected %0d, actual %0d",
								$time, exp_r.status, result.status);
						if (exp_r.granted_slot !== result.granted_slot)
							$display("%0t  granted_slot: expected %0d, actual %0d",
								$time, exp_r.granted_slot, result.granted_slot);
						errors++;
					end
				end
			end
			if (start && !busy) rsp_q.push_back(serve(req));
			pending = rsp_q.size();
		end
	end
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the task slot lifecycle tracker: directed corner
// requests, then random lifecycle traffic; checking lives in tslt_checker.
// ----------------------------------------------------------------------------
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	tslt_pkg::req_t req = '0;
	logic busy;
	logic done;
	tslt_pkg::rsp_t result;
	int errors;
	int pending;
	int idle_pct;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task_slot_lifecycle_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	tslt_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	// One transfer: optional random gap, then hold start until accepted.
	// start stays high across back-to-back transfers (no drop/raise per step).
	task automatic send(input logic [1:0] t, input logic [5:0] s,
			input logic [2:0] f, input logic [2:0] d);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req <= '{req_type: t, slot_number: s, from_state: f, to_state: d};
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_rand(input int n);
		logic [2:0] f;
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			f = 3'($urandom_range(4));
			if (pick < 30)
				send(tslt_pkg::REQ_ALLOC, 6'($urandom), 3'($urandom), 3'($urandom));
			else if (pick < 75) begin
				// mostly legal pairs with random slots to walk the lifecycle
				case (f)
					tslt_pkg::ST_FREE:
						send(tslt_pkg::REQ_MOVE, 6'($urandom), f, tslt_pkg::ST_REQUEST);
					tslt_pkg::ST_REQUEST:
						send(tslt_pkg::REQ_MOVE, 6'($urandom), f, $urandom_range(1) ?
							3'($urandom_range(2, 4)) : tslt_pkg::ST_FREE);
					tslt_pkg::ST_PREPARE:
						send(tslt_pkg::REQ_MOVE, 6'($urandom), f, $urandom_range(1) ?
							3'($urandom_range(3, 4)) : tslt_pkg::ST_FREE);
					tslt_pkg::ST_PROCESS:
						send(tslt_pkg::REQ_MOVE, 6'($urandom), f, $urandom_range(1) ?
							tslt_pkg::ST_COMPLETE : tslt_pkg::ST_FREE);
					default: send(tslt_pkg::REQ_MOVE, 6'($urandom), f, tslt_pkg::ST_FREE);
				endcase
			end
			else if (pick < 83)
				send(tslt_pkg::REQ_MOVE, 6'($urandom), 3'($urandom), 3'($urandom));
			else if (pick < 97)
				send(tslt_pkg::REQ_RELEASE, 6'($urandom), 3'($urandom), 3'($urandom));
			else
				send(tslt_pkg::REQ_FLUSH, 6'($urandom), 3'($urandom), 3'($urandom));
		end
	endtask

	initial begin
		idle_pct = 19;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bad slot, illegal pairs incl. codes 5..7, empty source,
		// wrong state, release of free slot, then drain the pool
		send(tslt_pkg::REQ_MOVE, 6'd0, tslt_pkg::ST_FREE, tslt_pkg::ST_REQUEST);
		send(tslt_pkg::REQ_RELEASE, 6'd0, tslt_pkg::ST_FREE, tslt_pkg::ST_FREE);
		send(tslt_pkg::REQ_MOVE, 6'd5, 3'd7, 3'd7);
		send(tslt_pkg::REQ_MOVE, 6'd5, tslt_pkg::ST_FREE, 3'd5);
		send(tslt_pkg::REQ_MOVE, 6'd5, tslt_pkg::ST_COMPLETE, tslt_pkg::ST_REQUEST);
		send(tslt_pkg::REQ_MOVE, 6'd5, tslt_pkg::ST_PREPARE, tslt_pkg::ST_PROCESS);
		send(tslt_pkg::REQ_RELEASE, 6'd63, tslt_pkg::ST_FREE, tslt_pkg::ST_FREE);
		send(tslt_pkg::REQ_ALLOC, 6'h3f, 3'h7, 3'h7);
		send(tslt_pkg::REQ_MOVE, 6'd2, tslt_pkg::ST_REQUEST, tslt_pkg::ST_PREPARE);
		send(tslt_pkg::REQ_MOVE, 6'd1, tslt_pkg::ST_REQUEST, tslt_pkg::ST_PREPARE);
		send(tslt_pkg::REQ_MOVE, 6'd1, tslt_pkg::ST_PREPARE, tslt_pkg::ST_PROCESS);
		send(tslt_pkg::REQ_MOVE, 6'd1, tslt_pkg::ST_PROCESS, tslt_pkg::ST_COMPLETE);
		send(tslt_pkg::REQ_MOVE, 6'd1, tslt_pkg::ST_COMPLETE, tslt_pkg::ST_FREE);
		send(tslt_pkg::REQ_MOVE, 6'd63, tslt_pkg::ST_FREE, tslt_pkg::ST_REQUEST);
		send(tslt_pkg::REQ_RELEASE, 6'd63, tslt_pkg::ST_FREE, tslt_pkg::ST_FREE);
		for (int i = 0; i < 64; i++)
			send(tslt_pkg::REQ_ALLOC, 6'd0, tslt_pkg::ST_FREE, tslt_pkg::ST_FREE);
		send(tslt_pkg::REQ_FLUSH, 6'h3f, 3'h7, 3'h7);

		send_rand(170);
		idle_pct = 47;
		send_rand(170);
		idle_pct = 0;
		send_rand(170);
		start <= 1'b0;

		// wait for the last transfer to complete
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[files.f]
design/tslt_pkg.sv
design/tslt_mem.sv
design/tslt_ctrl.sv
design/task_slot_lifecycle_tracker.sv
sim/tslt_checker.sv
sim/tb.sv
